// ===== src/sqkr_pkg.sv =====
`timescale 1ns / 1ps

package sqkr_pkg;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int SERIAL_W = 31;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_POP    = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    // Answer codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_NOTFOUND = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_HEAD
    } state_t;

    // Flags from the shared step/compare unit
    typedef struct packed {
        logic match;          // slot data hits the key (or forced for pop)
        logic step_in_range;  // stepped pointer is below the count
        logic next_in_range;  // stepped pointer plus one is below the count
    } step_flags_t;

endpackage

// ===== src/shift_queue_with_key_removal_core.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Handshake          | Payload (lowest bit up)
// s_      | in  | s_tvalid/s_tready  | mode[1:0], serial[32:2], zero[39:33]
// m_      | out | m_tvalid/m_tready  | status[1:0], removed_serial[32:2],
//         |     |                    | count[37:33], zero[39:38]
//
// Append, insert into an empty queue, and any refused or empty request
// answer straight from S_IDLE. Insert at head into a non-empty queue
// shifts each slot up (S_SHIFT_RD, S_SHIFT_WR), then writes the head (S_HEAD);
// pop and remove search (S_SRCH_RD, S_SRCH_CMP) and shift down over the gap:
// one RAM read/write pair and the shared step/compare unit do a slot a step.
// s_tready is high only when the sequencer is idle and no result is pending.
// Reset (aresetn low, synchronous) clears the count and control; slot
// contents are not cleared. A stalled m_ side holds the block off s_.

module shift_queue_with_key_removal_core
    import sqkr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // mode[1:0], serial[32:2]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[1:0], removed_serial[32:2], count[37:33]
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                state_reg, state_next;
    mode_t                 op_reg, op_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic [SERIAL_W-1:0]   key_reg, key_next;
    logic [SERIAL_W-1:0]   rem_reg, rem_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [SERIAL_W-1:0]   m_removed_reg, m_removed_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;

    logic                  s_accept;
    mode_t                 in_mode;
    logic [SERIAL_W-1:0]   in_serial;
    logic                  full;
    logic                  empty;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [SERIAL_W-1:0]   ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [SERIAL_W-1:0]   ram_rdata;

    logic [CNT_W-1:0]      step;
    step_flags_t           flags;
    logic                  step_dec;

    assign in_mode   = mode_t'(s_tdata[MODE_W-1:0]);
    assign in_serial = s_tdata[MODE_W +: SERIAL_W];
    assign s_tready  = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign step_dec  = (op_reg == MODE_INSERT);

    // Slot storage
    sqkr_ram #(
        .WIDTH (SERIAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared pointer step and key compare
    sqkr_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .ptr       (ptr_reg),
        .cnt       (cnt_reg),
        .dec       (step_dec),
        .force_hit (op_reg == MODE_POP),
        .rdata     (ram_rdata),
        .key       (key_reg),
        .step      (step),
        .flags     (flags)
    );

    // Sequencer state and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        ptr_reg       <= ptr_next;
        key_reg       <= key_next;
        rem_reg       <= rem_next;
        m_status_reg  <= m_status_next;
        m_removed_reg <= m_removed_next;
        m_count_reg   <= m_count_next;
    end

    // Next state, RAM control and result loading
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_removed_next = m_removed_reg;
        m_count_next   = m_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[AW-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = ptr_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next  = in_mode;
                    key_next = in_serial;
                    rem_next = '0;
                    ptr_next = '0;
                    // default answer for refused or empty requests
                    m_valid_next   = 1'b1;
                    m_removed_next = '0;
                    m_count_next   = COUNT_W'(cnt_reg);
                    case (in_mode)
                        MODE_APPEND, MODE_INSERT: begin
                            if (full) begin
                                m_status_next = STATUS_FULL;
                            end else if (in_mode == MODE_APPEND || empty) begin
                                ram_we        = 1'b1;
                                ram_waddr     = cnt_reg[AW-1:0];
                                ram_wdata     = in_serial;
                                cnt_next      = cnt_reg + CNT_W'(1);
                                m_status_next = STATUS_OK;
                                m_count_next  = COUNT_W'(cnt_reg + CNT_W'(1));
                            end else begin
                                m_valid_next = 1'b0;
                                ptr_next     = cnt_reg;
                                state_next   = S_SHIFT_RD;
                            end
                        end
                        MODE_POP, MODE_REMOVE: begin
                            if (empty) begin
                                m_status_next = STATUS_EMPTY;
                            end else begin
                                m_valid_next = 1'b0;
                                state_next   = S_SRCH_RD;
                            end
                        end
                        default: begin
                            m_status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            S_SRCH_RD: begin
                ram_raddr  = ptr_reg[AW-1:0];
                state_next = S_SRCH_CMP;
            end

            S_SRCH_CMP: begin
                if (flags.match) begin
                    rem_next = ram_rdata;
                    if (flags.step_in_range) begin
                        state_next = S_SHIFT_RD;
                    end else begin
                        cnt_next       = cnt_reg - CNT_W'(1);
                        m_valid_next   = 1'b1;
                        m_status_next  = STATUS_OK;
                        m_removed_next = ram_rdata;
                        m_count_next   = COUNT_W'(cnt_reg - CNT_W'(1));
                        state_next     = S_IDLE;
                    end
                end else if (flags.step_in_range) begin
                    ptr_next   = step;
                    state_next = S_SRCH_RD;
                end else begin
                    m_valid_next   = 1'b1;
                    m_status_next  = STATUS_NOTFOUND;
                    m_removed_next = '0;
                    m_count_next   = COUNT_W'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end

            S_SHIFT_RD: begin
                // neighbor toward the source side of the move
                ram_raddr  = step[AW-1:0];
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
                ptr_next  = step;
                if (step_dec) begin
                    state_next = (ptr_reg == CNT_W'(1)) ? S_HEAD : S_SHIFT_RD;
                end else if (flags.next_in_range) begin
                    state_next = S_SHIFT_RD;
                end else begin
                    cnt_next       = cnt_reg - CNT_W'(1);
                    m_valid_next   = 1'b1;
                    m_status_next  = STATUS_OK;
                    m_removed_next = rem_reg;
                    m_count_next   = COUNT_W'(cnt_reg - CNT_W'(1));
                    state_next     = S_IDLE;
                end
            end

            S_HEAD: begin
                ram_we         = 1'b1;
                ram_waddr      = '0;
                ram_wdata      = key_reg;
                cnt_next       = cnt_reg + CNT_W'(1);
                m_valid_next   = 1'b1;
                m_status_next  = STATUS_OK;
                m_removed_next = '0;
                m_count_next   = COUNT_W'(cnt_reg + CNT_W'(1));
                state_next     = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result port
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W - SERIAL_W - COUNT_W){1'b0}},
                       m_count_reg, m_removed_reg, m_status_reg};

    // Count never passes the queue depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // Slot writes happen only on an accepted beat or inside a sequence
    a_we_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (s_accept || state_reg != S_IDLE))
        else $error("slot write while idle");

    // A pending result reports the count actually held
    a_cnt_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_count_reg == COUNT_W'(cnt_reg)))
        else $error("reported count differs from held count");

    // Gap closing never writes past the second-to-last slot
    a_fwd_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_WR && !step_dec) |->
            ({1'b0, ptr_reg} + (CNT_W+1)'(1) < {1'b0, cnt_reg}))
        else $error("forward shift beyond tail");

    // No result is produced while the sequencer is busy with an item
    a_busy_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE && !m_valid_reg) |=> !($rose(m_valid_reg) && state_reg != S_IDLE))
        else $error("result raised mid-sequence");

endmodule

// ===== src/sqkr_ram.sv =====
`timescale 1ns / 1ps

module sqkr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sqkr_step.sv =====
`timescale 1ns / 1ps

module sqkr_step
    import sqkr_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  logic [CNT_W-1:0]    ptr,
    input  logic [CNT_W-1:0]    cnt,
    input  logic                dec,
    input  logic                force_hit,
    input  logic [SERIAL_W-1:0] rdata,
    input  logic [SERIAL_W-1:0] key,
    output logic [CNT_W-1:0]    step,
    output step_flags_t         flags
);

    logic [CNT_W:0] step_plus;

    // Shared pointer adder, both directions
    assign step      = dec ? (ptr - CNT_W'(1)) : (ptr + CNT_W'(1));
    assign step_plus = {1'b0, step} + (CNT_W+1)'(1);

    // Key compare and bounds checks
    assign flags.match         = force_hit || (rdata == key);
    assign flags.step_in_range = (step < cnt);
    assign flags.next_in_range = (step_plus < {1'b0, cnt});

endmodule

// ===== test/shift_queue_with_key_removal_core_test.sv =====
`timescale 1ns / 1ps

module shift_queue_with_key_removal_core_test;
    import sqkr_pkg::*;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 4000;   // cycles with no beat on either side
    localparam int DRAIN_WAIT  = 120;    // extra wait once every answer has been taken

    typedef logic [SERIAL_W-1:0] serial_t;

    typedef struct packed {
        status_t             status;
        serial_t             removed;
        logic [COUNT_W-1:0]  count;
    } answer_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // mode[1:0], serial[32:2], zero[39:33]
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // status[1:0], removed_serial[32:2], count[37:33], zero[39:38]

    // Shadow copy of the queue contents
    serial_t model_slots [DEPTH+1];
    int      model_fill;

    answer_t pending_answers [$];
    int      error_count;
    int      quiet_cycles;
    bit      gaps_enabled;

    shift_queue_with_key_removal_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return gaps_enabled ? $urandom_range(0, 8) : 0;
    endfunction

    // Apply one request to the shadow queue and return the answer it earns
    function automatic answer_t queue_apply(mode_t mode, serial_t serial);
        answer_t ans;
        int      hit;
        ans.status  = STATUS_OK;
        ans.removed = '0;
        hit         = -1;
        case (mode)
            MODE_APPEND, MODE_INSERT: begin
                if (model_fill >= DEPTH) begin
                    ans.status = STATUS_FULL;
                end else if (mode == MODE_APPEND) begin
                    model_slots[model_fill] = serial;
                    model_fill++;
                end else begin
                    for (int k = model_fill; k > 0; k--)
                        model_slots[k] = model_slots[k-1];
                    model_slots[0] = serial;
                    model_fill++;
                end
            end
            MODE_POP: begin
                if (model_fill == 0) ans.status = STATUS_EMPTY;
                else hit = 0;
            end
            default: begin
                if (model_fill == 0) begin
                    ans.status = STATUS_EMPTY;
                end else begin
                    // first match from the head wins
                    for (int k = 0; k < model_fill; k++)
                        if (hit < 0 && model_slots[k] == serial) hit = k;
                    if (hit < 0) ans.status = STATUS_NOTFOUND;
                end
            end
        endcase
        // Close the gap left by a pop or removal
        if (hit >= 0) begin
            ans.removed = model_slots[hit];
            for (int k = hit; k < model_fill - 1; k++)
                model_slots[k] = model_slots[k+1];
            model_fill--;
        end
        ans.count = COUNT_W'(model_fill);
        return ans;
    endfunction

    function automatic bit queue_holds(serial_t key);
        for (int k = 0; k < model_fill; k++)
            if (model_slots[k] == key) return 1'b1;
        return 1'b0;
    endfunction

    function automatic serial_t random_serial();
        // small values now and then so keys repeat
        if ($urandom_range(0, 3) == 0) return serial_t'($urandom_range(0, 7));
        return serial_t'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 50)
            $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Send one request beat; called and returns at a falling edge
    task automatic send_request(input mode_t mode, input serial_t serial);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, serial, mode};
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(queue_apply(mode, serial));
        @(negedge aclk);
    endtask

    // Pop and remove on an empty queue
    task automatic test_empty_requests();
        send_request(MODE_POP, 31'h7FFF_FFFF);
        send_request(MODE_REMOVE, '0);
    endtask

    // Fill to DEPTH with both ends, extremes and a duplicate key
    task automatic test_fill_to_full();
        send_request(MODE_INSERT, 31'h7FFF_FFFF);
        send_request(MODE_APPEND, '0);
        send_request(MODE_APPEND, 31'h2AAA_AAAA);
        send_request(MODE_INSERT, 31'h5555_5555);
        send_request(MODE_APPEND, '0);
        while (model_fill < DEPTH)
            send_request(model_fill[0] ? MODE_INSERT : MODE_APPEND, serial_t'($urandom));
    endtask

    // Both insert modes refused while full
    task automatic test_full_refusals();
        send_request(MODE_APPEND, 31'h1234_5678);
        send_request(MODE_INSERT, 31'h7FFF_FFFF);
    endtask

    // Duplicate and zero key, absent key, head, pop, tail key
    task automatic test_remove_cases();
        serial_t key;
        send_request(MODE_REMOVE, '0);
        do key = serial_t'($urandom); while (queue_holds(key));
        send_request(MODE_REMOVE, key);
        send_request(MODE_REMOVE, model_slots[0]);
        send_request(MODE_POP, '0);
        send_request(MODE_REMOVE, model_slots[model_fill-1]);
    endtask

    // Random traffic with a fill bias that drifts between empty and full
    task automatic test_random_traffic(input int n_items);
        int      grow_pct;
        mode_t   mode;
        serial_t serial;
        grow_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 4))
                    0: grow_pct = 10;
                    1: grow_pct = 30;
                    2: grow_pct = 50;
                    3: grow_pct = 70;
                    default: grow_pct = 90;
                endcase
                gaps_enabled = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < grow_pct)
                mode = $urandom_range(0, 1) ? MODE_APPEND : MODE_INSERT;
            else
                mode = $urandom_range(0, 1) ? MODE_POP : MODE_REMOVE;
            serial = random_serial();
            // most removals aim at a stored entry
            if (mode == MODE_REMOVE && model_fill > 0 && $urandom_range(0, 9) < 7)
                serial = model_slots[$urandom_range(0, model_fill - 1)];
            send_request(mode, serial);
        end
    endtask

    // Result side ready pattern
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result beat with no request outstanding", m_tdata[31:0], 0);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                if (m_tdata[32:2] !== want.removed)
                    report_mismatch("removed_serial", 32'(m_tdata[32:2]), 32'(want.removed));
                if (m_tdata[37:33] !== want.count)
                    report_mismatch("count", 32'(m_tdata[37:33]), 32'(want.count));
                if (m_tdata[39:38] !== 2'b00)
                    report_mismatch("pad bits", 32'(m_tdata[39:38]), 0);
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        model_fill   = 0;
        error_count  = 0;
        quiet_cycles = 0;
        gaps_enabled = 1'b1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_requests();
        test_fill_to_full();
        test_full_refusals();
        test_remove_cases();
        test_random_traffic(1400);

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/sqkr_pkg.sv
src/sqkr_ram.sv
src/sqkr_step.sv
src/shift_queue_with_key_removal_core.sv
test/shift_queue_with_key_removal_core_test.sv
